>>> src/krt_pkg.sv
// krt_pkg: shared types and constants for the keyed record table
// used by krt_ctrl, krt_dp and keyed_record_table
`default_nettype none

package krt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // field widths
    localparam int CMD_W  = 3;
    localparam int KEY_W  = 31;
    localparam int AGE_W  = 8;
    localparam int SAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MAX    = 3'd5;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [SAL_W-1:0] salary;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RMV_SEARCH,
        S_SHIFT,
        S_MAX,
        S_LIST,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    rd_zero;
        logic    rd_adv;
        logic    latch_in;
        logic    append;
        logic    set_status;
        t_status status;
        logic    take_entry;
        logic    shift_wr;
        logic    fill_dec;
        logic    out_list;
        logic    out_res;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic at_last;
        logic greater;
        logic first;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/krt_ctrl.sv
// krt_ctrl: command sequencer for the keyed record table
// depends on krt_pkg; drives krt_dp through t_dp_cmd
`default_nettype none

module krt_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [krt_pkg::CMD_W-1:0] i_command,
    output logic                          o_in_ready,
    input  wire krt_pkg::t_dp_stat        i_stat,
    output krt_pkg::t_dp_cmd              o_cmd
);
    import krt_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_APPEND: n_state = S_EMIT;
                        CMD_COUNT:  n_state = S_EMIT;
                        CMD_LIST:   n_state = i_stat.empty ? S_EMIT : S_LIST;
                        CMD_SEARCH: n_state = i_stat.empty ? S_EMIT : S_SEARCH;
                        CMD_REMOVE: n_state = i_stat.empty ? S_EMIT : S_RMV_SEARCH;
                        CMD_MAX:    n_state = i_stat.empty ? S_EMIT : S_MAX;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_stat.match || i_stat.at_last) begin
                    n_state = S_EMIT;
                end
            end
            S_RMV_SEARCH: begin
                if (i_stat.match) begin
                    n_state = i_stat.at_last ? S_EMIT : S_SHIFT;
                end else if (i_stat.at_last) begin
                    n_state = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (i_stat.at_last) begin
                    n_state = S_EMIT;
                end
            end
            S_MAX: begin
                if (i_stat.at_last) begin
                    n_state = S_EMIT;
                end
            end
            S_LIST: begin
                if (i_stat.out_free && i_stat.at_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.rd_zero = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    case (i_command)
                        CMD_APPEND: begin
                            if (i_stat.full) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = ST_FULL;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                        CMD_COUNT: begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_OK;
                        end
                        CMD_LIST, CMD_SEARCH, CMD_REMOVE, CMD_MAX: begin
                            if (i_stat.empty) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = ST_EMPTY;
                            end
                        end
                        default: o_cmd.latch_in = 1'b0;
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_stat.match) begin
                    o_cmd.take_entry = 1'b1;
                end else if (i_stat.at_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOTFOUND;
                end else begin
                    o_cmd.rd_adv = 1'b1;
                end
            end
            S_RMV_SEARCH: begin
                if (i_stat.match) begin
                    o_cmd.take_entry = 1'b1;
                    if (i_stat.at_last) begin
                        o_cmd.fill_dec = 1'b1;
                    end else begin
                        o_cmd.rd_adv = 1'b1;
                    end
                end else if (i_stat.at_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOTFOUND;
                end else begin
                    o_cmd.rd_adv = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                if (i_stat.at_last) begin
                    o_cmd.fill_dec = 1'b1;
                end else begin
                    o_cmd.rd_adv = 1'b1;
                end
            end
            S_MAX: begin
                o_cmd.take_entry = i_stat.first || i_stat.greater;
                o_cmd.rd_adv     = !i_stat.at_last;
            end
            S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_list = 1'b1;
                    o_cmd.rd_adv   = !i_stat.at_last;
                end
            end
            S_EMIT: begin
                o_cmd.out_res = i_stat.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // a removal always ends in the result beat
    a_dec_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill_dec |=> (r_state == S_EMIT))
        else $error("fill decrement not followed by result");

    // a pending result goes out and the sequencer is free again
    a_res_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_res |=> (r_state == S_IDLE))
        else $error("result beat not followed by idle");

    // undefined command codes leave the sequencer idle
    a_unknown_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && (i_command > CMD_MAX))
        |=> (r_state == S_IDLE))
        else $error("undefined command started work");

endmodule

`default_nettype wire

>>> src/krt_dp.sv
// krt_dp: record memory, scan pointer, result and output registers
// depends on krt_pkg; controlled by krt_ctrl through t_dp_cmd
`default_nettype none

module krt_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire krt_pkg::t_dp_cmd         i_cmd,
    output krt_pkg::t_dp_stat             o_stat,
    input  wire logic [krt_pkg::KEY_W-1:0] i_key,
    input  wire logic [krt_pkg::AGE_W-1:0] i_age,
    input  wire logic [krt_pkg::SAL_W-1:0] i_salary,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic [krt_pkg::STAT_W-1:0]    o_status,
    output logic [krt_pkg::KEY_W-1:0]     o_rec_key,
    output logic [krt_pkg::AGE_W-1:0]     o_rec_age,
    output logic [krt_pkg::SAL_W-1:0]     o_rec_salary,
    output logic [krt_pkg::CNT_W-1:0]     o_entry_count,
    output logic                          o_last
);
    import krt_pkg::*;

    t_entry               r_mem [TABLE_DEPTH];
    t_entry               r_rdata;
    logic [IDX_W-1:0]     r_ptr;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     ptr_inc;
    logic [IDX_W-1:0]     ptr_dec;
    logic [IDX_W-1:0]     last_idx;
    logic [CNT_W-1:0]     r_fill;
    logic [KEY_W-1:0]     r_key;
    t_entry               r_res;
    t_status              r_res_status;
    logic                 r_out_valid;
    t_entry               r_out;
    t_status              r_out_status;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_last;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_entry               wr_data;
    t_entry               in_entry;

    assign in_entry = '{key: i_key, age: i_age, salary: i_salary};
    assign ptr_inc  = IDX_W'(r_ptr + 1'b1);
    assign ptr_dec  = IDX_W'(r_ptr - 1'b1);
    assign last_idx = IDX_W'(r_fill - 1'b1);

    // read address: restart at the top, step on, or re-read the same entry
    always_comb begin
        if (i_cmd.rd_zero) begin
            rd_addr = '0;
        end else if (i_cmd.rd_adv) begin
            rd_addr = ptr_inc;
        end else begin
            rd_addr = r_ptr;
        end
    end

    // write port: append at the fill level, or move an entry down one place
    always_comb begin
        wr_en   = i_cmd.append || i_cmd.shift_wr;
        wr_addr = i_cmd.append ? r_fill[IDX_W-1:0] : ptr_dec;
        wr_data = i_cmd.append ? in_entry : r_rdata;
    end

    // record memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // scan pointer tracks the entry now in r_rdata
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= rd_addr;
        end
    end

    // fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.append) begin
            r_fill <= CNT_W'(r_fill + 1'b1);
        end else if (i_cmd.fill_dec) begin
            r_fill <= CNT_W'(r_fill - 1'b1);
        end
    end

    // search key and pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_key <= i_key;
        end
        if (i_cmd.append) begin
            r_res        <= in_entry;
            r_res_status <= ST_OK;
        end else if (i_cmd.set_status) begin
            r_res        <= '0;
            r_res_status <= i_cmd.status;
        end else if (i_cmd.take_entry) begin
            r_res        <= r_rdata;
            r_res_status <= ST_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_list || i_cmd.out_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_list) begin
            r_out        <= r_rdata;
            r_out_status <= ST_OK;
            r_out_count  <= r_fill;
            r_out_last   <= o_stat.at_last;
        end else if (i_cmd.out_res) begin
            r_out        <= r_res;
            r_out_status <= r_res_status;
            r_out_count  <= r_fill;
            r_out_last   <= 1'b1;
        end
    end

    // status toward the sequencer
    always_comb begin
        o_stat.empty    = (r_fill == '0);
        o_stat.full     = (r_fill == CNT_W'(TABLE_DEPTH));
        o_stat.match    = (r_rdata.key == r_key);
        o_stat.at_last  = (r_ptr == last_idx);
        o_stat.greater  = (r_rdata.salary > r_res.salary);
        o_stat.first    = (r_ptr == '0);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_rec_key     = r_out.key;
    assign o_rec_age     = r_out.age;
    assign o_rec_salary  = r_out.salary;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

    // fill level stays within the table
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill level beyond table depth");

    // a shift moves a live entry into a live slot
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |-> (r_ptr != '0 && CNT_W'(r_ptr) < r_fill))
        else $error("shift outside live entries");

    // fill level moves by at most one per cycle
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_fill == $past(r_fill) || r_fill == CNT_W'($past(r_fill) + 1'b1)
             || r_fill == CNT_W'($past(r_fill) - 1'b1)))
        else $error("fill level jumped");

    // the final list beat carries the last marker
    a_list_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_list && o_stat.at_last) |=> (r_out_valid && r_out_last))
        else $error("list end without last marker");

endmodule

`default_nettype wire

>>> src/keyed_record_table.sv
// keyed_record_table: ordered record table, top level
// depends on krt_pkg, krt_ctrl and krt_dp
//
//  channel  signals                                          direction
//  in       i_in_valid/o_in_ready, command key age salary    into block
//  out      o_out_valid/i_out_ready, status rec_key rec_age  out of block
//           rec_salary entry_count last
//
// append and count: no scan; the result goes straight to the result beat
// search reads one entry a cycle and stops at the first hit or at the last entry
// remove and max salary scan to the end; remove moves entries as it goes
// list gives one beat a cycle while the output is taken; stalls hold the scan
// reset (synchronous, active low) empties the table; no clearing pass
`default_nettype none

module keyed_record_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [krt_pkg::CMD_W-1:0]  i_command,
    input  wire logic [krt_pkg::KEY_W-1:0]  i_key,
    input  wire logic [krt_pkg::AGE_W-1:0]  i_age,
    input  wire logic [krt_pkg::SAL_W-1:0]  i_salary,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [krt_pkg::STAT_W-1:0]     o_status,
    output logic [krt_pkg::KEY_W-1:0]      o_rec_key,
    output logic [krt_pkg::AGE_W-1:0]      o_rec_age,
    output logic [krt_pkg::SAL_W-1:0]      o_rec_salary,
    output logic [krt_pkg::CNT_W-1:0]      o_entry_count,
    output logic                           o_last
);
    import krt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // memory and result path
    krt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_key         (i_key),
        .i_age         (i_age),
        .i_salary      (i_salary),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_rec_key     (o_rec_key),
        .o_rec_age     (o_rec_age),
        .o_rec_salary  (o_rec_salary),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: self-checking bench for the keyed record table, all commands through
// the valid/ready channels with random idling and back pressure; needs krt_pkg and
// keyed_record_table
`timescale 1ns / 100ps

module testbench;
    import krt_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER = 40;
    localparam int IDLE_PCT = 23;
    localparam int KEY_POOL_N = 12;
    localparam int MAX_REPORTS = 10;

    // command codes the block has to ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
    localparam logic [SAL_W-1:0] SAL_MAX = {SAL_W{1'b1}};

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [SAL_W-1:0] salary;
    } t_table_cmd;

    typedef struct packed {
        t_status          status;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [SAL_W-1:0] salary;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_table_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_command = '0;
    logic [KEY_W-1:0]    i_key = '0;
    logic [AGE_W-1:0]    i_age = '0;
    logic [SAL_W-1:0]    i_salary = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [KEY_W-1:0]    o_rec_key;
    logic [AGE_W-1:0]    o_rec_age;
    logic [SAL_W-1:0]    o_rec_salary;
    logic [CNT_W-1:0]    o_entry_count;
    logic                o_last;

    // shadow copy of the table
    logic [KEY_W-1:0]    shadow_key [TABLE_DEPTH];
    logic [AGE_W-1:0]    shadow_age [TABLE_DEPTH];
    logic [SAL_W-1:0]    shadow_salary [TABLE_DEPTH];
    int                  shadow_fill = 0;

    t_table_cmd          item_queue [$];
    t_table_result       results_due [$];
    t_table_cmd          offered_cmd;
    t_table_result       got_result;
    t_table_result       want_result;
    logic [KEY_W-1:0]    key_pool [KEY_POOL_N];

    bit                  in_pending = 1'b0;
    bit                  no_idle = 1'b0;
    bit                  holdoff_done = 1'b0;
    int                  holdoff_left = 0;
    int                  out_beats = 0;
    int                  mismatches = 0;
    int                  stall_cycles = 0;

    keyed_record_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_age         (i_age),
        .i_salary      (i_salary),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_rec_key     (o_rec_key),
        .o_rec_age     (o_rec_age),
        .o_rec_salary  (o_rec_salary),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // apply one command to the shadow table and queue the results it gives
    task automatic table_apply(input t_table_cmd c);
        t_table_result r;
        int            hit;
        int            best;
        bit            emit_one;
        r = '0;
        r.last = 1'b1;
        hit = -1;
        best = 0;
        emit_one = 1'b1;
        case (c.cmd)
            CMD_APPEND: begin
                if (shadow_fill >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_key[shadow_fill] = c.key;
                    shadow_age[shadow_fill] = c.age;
                    shadow_salary[shadow_fill] = c.salary;
                    shadow_fill++;
                    r.key = c.key;
                    r.age = c.age;
                    r.salary = c.salary;
                end
            end
            CMD_LIST: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    emit_one = 1'b0;
                    for (int i = 0; i < shadow_fill; i++) begin
                        r.key = shadow_key[i];
                        r.age = shadow_age[i];
                        r.salary = shadow_salary[i];
                        r.count = shadow_fill[CNT_W-1:0];
                        r.last = (i == shadow_fill - 1);
                        results_due.push_back(r);
                    end
                end
            end
            CMD_SEARCH, CMD_REMOVE: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (hit < 0 && shadow_key[i] == c.key) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.key = shadow_key[hit];
                        r.age = shadow_age[hit];
                        r.salary = shadow_salary[hit];
                        // remove closes the gap and keeps the order
                        if (c.cmd == CMD_REMOVE) begin
                            for (int i = hit; i < shadow_fill - 1; i++) begin
                                shadow_key[i] = shadow_key[i+1];
                                shadow_age[i] = shadow_age[i+1];
                                shadow_salary[i] = shadow_salary[i+1];
                            end
                            shadow_fill--;
                        end
                    end
                end
            end
            CMD_COUNT: begin
                r.status = ST_OK;
            end
            CMD_MAX: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // strict compare keeps the earliest on a tie
                    for (int i = 1; i < shadow_fill; i++) begin
                        if (shadow_salary[i] > shadow_salary[best]) best = i;
                    end
                    r.key = shadow_key[best];
                    r.age = shadow_age[best];
                    r.salary = shadow_salary[best];
                end
            end
            default: begin
                emit_one = 1'b0;
            end
        endcase
        if (emit_one) begin
            r.count = shadow_fill[CNT_W-1:0];
            results_due.push_back(r);
        end
    endtask

    function automatic t_table_cmd random_item(input int append_pct, input int remove_pct);
        t_table_cmd c;
        int         roll;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 85) c.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
        else c.key = KEY_W'($urandom());
        c.age = AGE_W'($urandom_range(255));
        if ($urandom_range(9) == 0) c.salary = SAL_MAX;
        else c.salary = $urandom();
        if (roll < append_pct) begin
            c.cmd = CMD_APPEND;
        end else if (roll < append_pct + remove_pct) begin
            c.cmd = CMD_REMOVE;
        end else begin
            roll = $urandom_range(99);
            if (roll < 35) c.cmd = CMD_SEARCH;
            else if (roll < 55) c.cmd = CMD_MAX;
            else if (roll < 70) c.cmd = CMD_COUNT;
            else if (roll < 88) c.cmd = CMD_LIST;
            else if (roll < 94) c.cmd = CMD_RSVD_A;
            else c.cmd = CMD_RSVD_B;
        end
        return c;
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [AGE_W-1:0] age, input logic [SAL_W-1:0] salary);
        item_queue.push_back('{cmd: cmd, key: key, age: age, salary: salary});
    endtask

    task automatic queue_phase(input int n, input int append_pct, input int remove_pct);
        repeat (n) item_queue.push_back(random_item(append_pct, remove_pct));
    endtask

    task automatic wait_drained();
        while (item_queue.size() != 0 || in_pending || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // input driver: next command beat at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!in_pending) begin
            if (item_queue.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                offered_cmd = item_queue.pop_front();
                in_pending = 1'b1;
                i_command <= offered_cmd.cmd;
                i_key <= offered_cmd.key;
                i_age <= offered_cmd.age;
                i_salary <= offered_cmd.salary;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (!holdoff_done && out_beats >= HOLDOFF_AFTER) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: check result beats, predict on command beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_beats++;
                got_result = {o_status, o_rec_key, o_rec_age, o_rec_salary,
                              o_entry_count, o_last};
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"unexpected result beat %0d: ",
                                  "st=%0d key=%h age=%h sal=%h cnt=%0d last=%b"},
                                 out_beats, got_result.status, got_result.key, got_result.age,
                                 got_result.salary, got_result.count, got_result.last);
                end else begin
                    want_result = results_due.pop_front();
                    if (got_result !== want_result) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"result beat %0d expected: ",
                                      "st=%0d key=%h age=%h sal=%h cnt=%0d last=%b"},
                                     out_beats, want_result.status, want_result.key,
                                     want_result.age, want_result.salary, want_result.count,
                                     want_result.last);
                            $display({"result beat %0d actual:   ",
                                      "st=%0d key=%h age=%h sal=%h cnt=%0d last=%b"},
                                     out_beats, got_result.status, got_result.key,
                                     got_result.age, got_result.salary, got_result.count,
                                     got_result.last);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                table_apply(offered_cmd);
                in_pending = 1'b0;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = KEY_W'($urandom());

        // empty table on every command but append
        push_cmd(CMD_COUNT,  '0, '0, '0);
        push_cmd(CMD_LIST,   '0, '0, '0);
        push_cmd(CMD_SEARCH, '0, '0, '0);
        push_cmd(CMD_REMOVE, '0, '0, '0);
        push_cmd(CMD_MAX,    '0, '0, '0);
        // field extremes and alternating bit patterns
        push_cmd(CMD_APPEND, '0, '0, '0);
        push_cmd(CMD_APPEND, KEY_MAX, AGE_MAX, SAL_MAX);
        push_cmd(CMD_APPEND, 31'h2AAA_AAAA, 8'h55, 32'hAAAA_AAAA);
        push_cmd(CMD_APPEND, 31'h5555_5555, 8'hAA, 32'h5555_5555);
        // duplicate key and a salary tie with the earlier record
        push_cmd(CMD_APPEND, '0, 8'd1, SAL_MAX);
        push_cmd(CMD_MAX,    '0, '0, '0);
        push_cmd(CMD_SEARCH, '0, '0, '0);
        push_cmd(CMD_SEARCH, 31'd12345, '0, '0);
        push_cmd(CMD_REMOVE, 31'h0123_4567, '0, '0);
        push_cmd(CMD_LIST,   '0, '0, '0);
        push_cmd(CMD_REMOVE, '0, '0, '0);
        push_cmd(CMD_LIST,   '0, '0, '0);
        push_cmd(CMD_COUNT,  '0, '0, '0);
        // ignored codes
        push_cmd(CMD_RSVD_A, KEY_MAX, AGE_MAX, SAL_MAX);
        push_cmd(CMD_RSVD_B, KEY_MAX, AGE_MAX, SAL_MAX);
        push_cmd(CMD_REMOVE, KEY_MAX, '0, '0);
        push_cmd(CMD_MAX,    '0, '0, '0);

        // mixed traffic while the receiver hold-off fills the block
        queue_phase(110, 45, 20);
        // fill burst up to full and past it
        queue_phase(80, 88, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender pause until every result is in
        wait_drained();
        @(posedge i_clk);
        no_idle = 1'b1;
        // drain-heavy traffic with no idling
        queue_phase(60, 25, 45);
        wait_drained();
        @(posedge i_clk);
        no_idle = 1'b0;
        queue_phase(70, 25, 45);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> keyed_record_table.f
src/krt_pkg.sv
src/krt_ctrl.sv
src/krt_dp.sv
src/keyed_record_table.sv
test/testbench.sv
